// ===== sv/euler_to_quaternion_core_defines.svh =====
// Assertion macros shared by the euler_to_quaternion_core RTL.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// Next-cycle check, disabled while reset is asserted.
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle check that also holds across reset.
`define E2Q_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/e2q_pkg.sv =====
// Package with constants and helper functions for the Euler to quaternion core.
`timescale 1ns / 1ps
package e2q_pkg;

    // Internal fixed-point value type, Q4.30 signed.
    typedef logic signed [33:0] t_fix;

    // Ceiling of 2^32 / 45, used to divide by 45 exactly for small operands.
    localparam logic [26:0] RECIP45 = 27'd95443718;

    // Round of pi/180 * 2^32.
    localparam logic [26:0] RAD_Q32 = 27'd74961321;

    // Minimax coefficients in Q2.30, highest order first.
    localparam t_fix SIN_C [6] = '{
        -34'sd26, 34'sd2956, -34'sd213040, 34'sd8947846, -34'sd178956974, 34'sd1073741824
    };
    localparam t_fix COS_C [6] = '{
        -34'sd280, 34'sd26586, -34'sd1491253, 34'sd44739212, -34'sd536870912,
        34'sd1073741824
    };

    // Q30 multiply with round to nearest, ties away from zero.
    function automatic t_fix qmul(input t_fix a, input t_fix b);
        logic signed [67:0] p;
        logic [67:0]        mag;
        logic [67:0]        sh;
        t_fix               v;
        p   = a * b;
        mag = p[67] ? 68'(-p) : 68'(p);
        sh  = (mag + (68'(1) << 29)) >> 30;
        v   = 34'(sh);
        return p[67] ? -v : v;
    endfunction

endpackage

// ===== sv/e2q_lane.sv =====
// One angle lane: modulo 360, fold, radian conversion and sine/cosine polynomials.
`timescale 1ns / 1ps
module e2q_lane #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_angle,
    output e2q_pkg::t_fix       o_sin,
    output e2q_pkg::t_fix       o_cos
);

    localparam int SH = ANGLE_FRAC_BITS + 3;
    localparam int TW = 32 - SH;
    localparam logic [33:0] FULL = 34'(360) << ANGLE_FRAC_BITS;
    localparam logic [33:0] HALF = 34'(180) << ANGLE_FRAC_BITS;

    // Stage 1: magnitude and quotient by 360 degrees (45 * 2^SH).
    logic [31:0]      w_mag;
    logic [TW-1:0]    w_t;
    logic [TW+26:0]   w_qprod;
    logic [31:0]      r_m;
    logic [TW-1:0]    r_q;
    logic             r_neg1;

    assign w_mag   = i_angle[31] ? 32'(-i_angle) : 32'(i_angle);
    assign w_t     = w_mag[31:SH];
    assign w_qprod = (TW+27)'(w_t) * (TW+27)'(e2q_pkg::RECIP45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= w_mag;
            r_q    <= TW'(w_qprod >> 32);
            r_neg1 <= i_angle[31];
        end
    end

    // Stage 2: remainder and fold into half a turn.
    logic [33:0] w_rem;
    logic [31:0] r_rmag;
    logic        r_flip2;
    logic        r_neg2;

    assign w_rem = 34'(r_m) - 34'(r_q) * FULL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_rem > HALF) begin
                r_rmag  <= 32'(FULL - w_rem);
                r_flip2 <= 1'b1;
            end else begin
                r_rmag  <= 32'(w_rem);
                r_flip2 <= 1'b0;
            end
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: scale to radians.
    logic [58:0] r_rad;
    logic        r_flip3;
    logic        r_neg3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad   <= 59'(r_rmag) * 59'(e2q_pkg::RAD_Q32);
            r_flip3 <= r_flip2;
            r_neg3  <= r_neg2;
        end
    end

    // Stage 4: round the half angle into Q2.30 and restore its sign.
    logic [58:0]   w_ymag;
    e2q_pkg::t_fix w_y;
    e2q_pkg::t_fix r_y4;
    logic          r_flip4;

    assign w_ymag = (r_rad + (59'(1) << (SH - 1))) >> SH;
    assign w_y    = r_neg3 ? -34'(w_ymag) : 34'(w_ymag);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y4    <= w_y;
            r_flip4 <= r_flip3;
        end
    end

    // Stage 5: square of the half angle.
    e2q_pkg::t_fix r_y_p  [0:5];
    e2q_pkg::t_fix r_y2_p [0:4];
    logic          r_flip_p [0:5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y_p[0]    <= r_y4;
            r_y2_p[0]   <= e2q_pkg::qmul(r_y4, r_y4);
            r_flip_p[0] <= r_flip4;
        end
    end

    // Horner stages, one coefficient per stage for both polynomials.
    e2q_pkg::t_fix r_acc_s [0:4];
    e2q_pkg::t_fix r_acc_c [0:4];

    for (genvar k = 0; k < 5; k++) begin : g_horner
        e2q_pkg::t_fix w_in_s;
        e2q_pkg::t_fix w_in_c;
        if (k == 0) begin : g_first
            assign w_in_s = e2q_pkg::SIN_C[0];
            assign w_in_c = e2q_pkg::COS_C[0];
        end else begin : g_next
            assign w_in_s = r_acc_s[k-1];
            assign w_in_c = r_acc_c[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc_s[k]    <= e2q_pkg::qmul(w_in_s, r_y2_p[k]) + e2q_pkg::SIN_C[k+1];
                r_acc_c[k]    <= e2q_pkg::qmul(w_in_c, r_y2_p[k]) + e2q_pkg::COS_C[k+1];
                r_y_p[k+1]    <= r_y_p[k];
                r_flip_p[k+1] <= r_flip_p[k];
                if (k < 4) begin
                    r_y2_p[(k < 4) ? k + 1 : 4] <= r_y2_p[k];
                end
            end
        end
    end

    // Final stage: odd polynomial times the angle, cosine sign from the fold.
    e2q_pkg::t_fix r_sin;
    e2q_pkg::t_fix r_cos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= e2q_pkg::qmul(r_acc_s[4], r_y_p[5]);
            r_cos <= r_flip_p[5] ? -r_acc_c[4] : r_acc_c[4];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== sv/e2q_merge.sv =====
// Merge stage: combines the three sine/cosine pairs into a saturated quaternion.
`timescale 1ns / 1ps
module e2q_merge #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  e2q_pkg::t_fix       i_sp,
    input  e2q_pkg::t_fix       i_cp,
    input  e2q_pkg::t_fix       i_sy,
    input  e2q_pkg::t_fix       i_cy,
    input  e2q_pkg::t_fix       i_sr,
    input  e2q_pkg::t_fix       i_cr,
    output logic signed [31:0]  o_quat_x,
    output logic signed [31:0]  o_quat_y,
    output logic signed [31:0]  o_quat_z,
    output logic signed [31:0]  o_quat_w
);

    localparam int SHO = 30 - OUT_FRAC_BITS;

    // Output rounding by SHO bits, then saturation to 32 bits.
    function automatic logic signed [31:0] finish(input logic signed [34:0] v);
        logic [34:0]        mag;
        logic [34:0]        sh;
        logic signed [35:0] o;
        mag = v[34] ? 35'(-v) : 35'(v);
        sh  = (mag + ((35'(1) << SHO) >> 1)) >> SHO;
        o   = v[34] ? -36'(sh) : 36'(sh);
        if (o > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (o < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(o);
    endfunction

    // Stage A: roll against pitch products.
    e2q_pkg::t_fix r_cs, r_sc, r_cc, r_ss, r_sy, r_cy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs <= e2q_pkg::qmul(i_cr, i_sp);
            r_sc <= e2q_pkg::qmul(i_sr, i_cp);
            r_cc <= e2q_pkg::qmul(i_cr, i_cp);
            r_ss <= e2q_pkg::qmul(i_sr, i_sp);
            r_sy <= i_sy;
            r_cy <= i_cy;
        end
    end

    // Stage B: products with yaw.
    e2q_pkg::t_fix r_p_cs_sy, r_p_sc_cy, r_p_cs_cy, r_p_sc_sy;
    e2q_pkg::t_fix r_p_cc_sy, r_p_ss_cy, r_p_cc_cy, r_p_ss_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_cs_sy <= e2q_pkg::qmul(r_cs, r_sy);
            r_p_sc_cy <= e2q_pkg::qmul(r_sc, r_cy);
            r_p_cs_cy <= e2q_pkg::qmul(r_cs, r_cy);
            r_p_sc_sy <= e2q_pkg::qmul(r_sc, r_sy);
            r_p_cc_sy <= e2q_pkg::qmul(r_cc, r_sy);
            r_p_ss_cy <= e2q_pkg::qmul(r_ss, r_cy);
            r_p_cc_cy <= e2q_pkg::qmul(r_cc, r_cy);
            r_p_ss_sy <= e2q_pkg::qmul(r_ss, r_sy);
        end
    end

    // Stage C: sums, rounding and saturation into the output register.
    logic signed [34:0] w_x, w_y, w_z, w_w;

    assign w_x = 35'(r_p_cs_sy) - 35'(r_p_sc_cy);
    assign w_y = -35'(r_p_cs_cy) - 35'(r_p_sc_sy);
    assign w_z = 35'(r_p_cc_sy) - 35'(r_p_ss_cy);
    assign w_w = 35'(r_p_cc_cy) + 35'(r_p_ss_sy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quat_x <= finish(w_x);
            o_quat_y <= finish(w_y);
            o_quat_z <= finish(w_z);
            o_quat_w <= finish(w_w);
        end
    end

endmodule

// ===== sv/euler_to_quaternion_core.sv =====
// An accepted item moves through the lane and merge stages to the output register.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a finished result waits at the output and the sink is not ready.
// Reset: synchronous, active low; it clears only the stage valid bits.
// Three angle lanes run in parallel, followed by a three-stage merge.
`timescale 1ns / 1ps
`include "euler_to_quaternion_core_defines.svh"
module euler_to_quaternion_core #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_pitch_deg,
    input  logic signed [31:0]  i_yaw_deg,
    input  logic signed [31:0]  i_roll_deg,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_quat_x,
    output logic signed [31:0]  o_quat_y,
    output logic signed [31:0]  o_quat_z,
    output logic signed [31:0]  o_quat_w
);

    localparam int LAT = 14;

    // Pipeline advance: move whenever the output slot is free or being taken.
    logic           w_en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];
    assign n_vld   = {r_vld[LAT-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // Angle lanes.
    e2q_pkg::t_fix w_sp, w_cp, w_sy, w_cy, w_sr, w_cr;

    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_pitch_deg), .o_sin(w_sp), .o_cos(w_cp)
    );
    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_yaw_deg), .o_sin(w_sy), .o_cos(w_cy)
    );
    e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_roll (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_roll_deg), .o_sin(w_sr), .o_cos(w_cr)
    );

    // Quaternion merge.
    e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
        .i_clk(i_clk), .i_en(w_en),
        .i_sp(w_sp), .i_cp(w_cp), .i_sy(w_sy), .i_cy(w_cy), .i_sr(w_sr), .i_cr(w_cr),
        .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z), .o_quat_w(o_quat_w)
    );

    // Checks on the valid pipeline.
    `E2Q_ASSERT_RST(a_rst_clears, !i_rst_n, !o_valid, "valid set after reset")
    `E2Q_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, r_vld[0], "accepted item lost")
    `E2Q_ASSERT_NEXT(a_stall_holds, !o_ready, $stable(r_vld), "pipeline moved while stalled")

endmodule
